// ===== rtl/xed_pkg.sv =====
// ----------------------------------------------------------------------------
// xed_pkg
// Shared types and constants of the XML entity decoder: payload structs,
// the job passed from the front end to the back end, and entity spellings.
// ----------------------------------------------------------------------------
package xed_pkg;

   localparam int HOLD_DEPTH  = 5;
   localparam int JOB_BYTES   = 6;
   localparam int NAME_COUNT  = 5;
   localparam int ALIVE_W     = 7;
   localparam int HEX_BIT     = 5;
   localparam int DEC_BIT     = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_X    = 8'h78;
   localparam logic [7:0] CH_SEMI = 8'h3b;
   localparam logic [7:0] CH_0    = 8'h30;
   localparam logic [7:0] CH_9    = 8'h39;
   localparam logic [7:0] CH_A    = 8'h61;
   localparam logic [7:0] CH_F    = 8'h66;
   localparam logic [7:0] HEX_OFS = 8'h57;

   localparam logic [7:0] DEC_MIN2 = 8'd12;
   localparam logic [7:0] DEC_MAX2 = 8'd25;
   localparam logic [7:0] DEC_MIN3 = 8'd128;
   localparam logic [11:0] DEC_MAX3 = 12'd255;

   // spellings of lt, gt, apos, quot, amp; entry 4 is the ampersand
   localparam logic [NAME_COUNT-1:0][JOB_BYTES-1:0][7:0] NAME_CHARS = '{
      '{8'h00, CH_SEMI, 8'h70, 8'h6d, 8'h61, CH_AMP},   // amp
      '{CH_SEMI, 8'h74, 8'h6f, 8'h75, 8'h71, CH_AMP},   // quot
      '{CH_SEMI, 8'h73, 8'h6f, 8'h70, 8'h61, CH_AMP},   // apos
      '{8'h00, 8'h00, CH_SEMI, 8'h74, 8'h67, CH_AMP},   // gt
      '{8'h00, 8'h00, CH_SEMI, 8'h74, 8'h6c, CH_AMP}    // lt
   };
   localparam logic [NAME_COUNT-1:0][2:0] NAME_LAST = '{3'd4, 3'd5, 3'd5, 3'd3, 3'd3};
   localparam logic [NAME_COUNT-1:0][7:0] NAME_VAL  = '{8'h26, 8'h22, 8'h27, 8'h3e, 8'h3c};

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       text_last;
   } rsp_type;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [2:0]                cnt;
      logic                      eot;
   } job_type;

endpackage

// ===== rtl/xml_entity_decoder_core.sv =====
// ----------------------------------------------------------------------------
// xml_entity_decoder_core
// Streaming XML character entity decoder: one text byte per transfer in,
// decoded bytes out, with a short job queue between classifier and emitter.
// ----------------------------------------------------------------------------
// A job passes the job queue, job register and output register. Throughput:
// one input byte per cycle while the queue has room; the emitter sends one
// result per cycle while the receiver is ready, holding each job until sent.
// Reset clears the held count, the job queue and the output register.
// ----------------------------------------------------------------------------
module xml_entity_decoder_core #(
   parameter int QUEUE_DEPTH = xed_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  xed_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output xed_pkg::rsp_type rsp_data
);
   import xed_pkg::*;

   logic    job_push;
   job_type job_data;
   logic    queue_full;
   logic    queue_valid;
   job_type queue_head;
   logic    job_pop;

   xed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_data   (job_data)
   );

   xed_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (job_pop),
      .full      (queue_full),
      .not_empty (queue_valid),
      .head      (queue_head)
   );

   xed_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job_head  (queue_head),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/xed_fifo.sv =====
// ----------------------------------------------------------------------------
// xed_fifo
// Short job queue between the classifying front end and the emitting back end.
// ----------------------------------------------------------------------------
module xed_fifo #(
   parameter int DEPTH = xed_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xed_pkg::job_type push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output xed_pkg::job_type head
);
   import xed_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/xed_front.sv =====
// ----------------------------------------------------------------------------
// xed_front
// Accepts text bytes, tracks which entities the held bytes can still become,
// and turns each decision into a job of one to six output bytes.
// ----------------------------------------------------------------------------
module xed_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  xed_pkg::req_type req_data,
   input  logic             queue_full,
   output logic             job_push,
   output xed_pkg::job_type job_data
);
   import xed_pkg::*;

   logic [HOLD_DEPTH-1:0][7:0] held_ff, held_in;
   logic [2:0]                 count_ff, count_in;
   logic [ALIVE_W-1:0]         alive_ff, alive_in;
   logic [7:0]                 acc_ff, acc_in;

   logic accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      logic [7:0]         nb;
      logic [2:0]         n;
      logic               eot;
      logic               is_digit;
      logic               is_hexd;
      logic [3:0]         dig;
      logic [3:0]         nib;
      logic [7:0]         sub_d;
      logic [7:0]         sub_h;
      logic [11:0]        dec_sum;
      logic [ALIVE_W-1:0] alive_nx;
      logic               done;
      logic [7:0]         done_val;
      logic               prefix;
      logic               rehold;

      nb  = req_data.in_byte;
      eot = req_data.end_of_text;
      n   = count_ff;

      sub_d    = nb - CH_0;
      sub_h    = nb - HEX_OFS;
      dig      = sub_d[3:0];
      is_digit = (nb >= CH_0) && (nb <= CH_9);
      is_hexd  = is_digit || ((nb >= CH_A) && (nb <= CH_F));
      nib      = is_digit ? dig : sub_h[3:0];
      dec_sum  = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {8'h00, dig};

      alive_nx = '0;
      done     = 1'b0;
      done_val = acc_ff;

      for (int k = 0; k < NAME_COUNT; k++) begin
         alive_nx[k] = alive_ff[k] && (n <= NAME_LAST[k]) && (nb == NAME_CHARS[k][n]);
         if (alive_nx[k] && (n == NAME_LAST[k])) begin
            done     = 1'b1;
            done_val = NAME_VAL[k];
         end
      end

      case (n)
         3'd0: begin
            alive_nx[HEX_BIT] = (nb == CH_AMP);
            alive_nx[DEC_BIT] = (nb == CH_AMP);
         end
         3'd1: begin
            alive_nx[HEX_BIT] = alive_ff[HEX_BIT] && (nb == CH_HASH);
            alive_nx[DEC_BIT] = alive_ff[DEC_BIT] && (nb == CH_HASH);
         end
         3'd2: begin
            alive_nx[HEX_BIT] = alive_ff[HEX_BIT] && (nb == CH_X);
            alive_nx[DEC_BIT] = alive_ff[DEC_BIT] && is_digit &&
                                ((dig == 4'd1) || (dig == 4'd2));
         end
         3'd3: begin
            alive_nx[HEX_BIT] = alive_ff[HEX_BIT] && is_hexd && nib[3];
            alive_nx[DEC_BIT] = alive_ff[DEC_BIT] && is_digit &&
                                (dec_sum >= {4'h0, DEC_MIN2}) &&
                                (dec_sum <= {4'h0, DEC_MAX2});
         end
         3'd4: begin
            alive_nx[HEX_BIT] = alive_ff[HEX_BIT] && is_hexd;
            alive_nx[DEC_BIT] = alive_ff[DEC_BIT] && is_digit &&
                                (dec_sum >= {4'h0, DEC_MIN3}) && (dec_sum <= DEC_MAX3);
         end
         3'd5: begin
            alive_nx[HEX_BIT] = alive_ff[HEX_BIT] && (nb == CH_SEMI);
            alive_nx[DEC_BIT] = alive_ff[DEC_BIT] && (nb == CH_SEMI);
            if (alive_nx[HEX_BIT] || alive_nx[DEC_BIT]) begin
               done     = 1'b1;
               done_val = acc_ff;
            end
         end
         default: begin
            alive_nx[HEX_BIT] = 1'b0;
            alive_nx[DEC_BIT] = 1'b0;
         end
      endcase

      if (alive_ff[HEX_BIT] && (n == 3'd3)) begin
         acc_in = {4'h0, nib};
      end else if (alive_ff[HEX_BIT] && (n == 3'd4)) begin
         acc_in = {acc_ff[3:0], nib};
      end else if (n == 3'd2) begin
         acc_in = {4'h0, dig};
      end else if ((n == 3'd3) || (n == 3'd4)) begin
         acc_in = dec_sum[7:0];
      end else begin
         acc_in = acc_ff;
      end

      prefix = !done && (alive_nx != '0);
      rehold = !done && !prefix && (nb == CH_AMP) && !eot;

      for (int i = 0; i < JOB_BYTES; i++) begin
         job_data.bytes[i] = nb;
      end
      for (int i = 0; i < HOLD_DEPTH; i++) begin
         if (3'(i) < n) begin
            job_data.bytes[i] = held_ff[i];
         end
      end
      job_data.eot = eot;
      if (done) begin
         job_data.bytes[0] = done_val;
         job_data.cnt      = 3'd1;
      end else if (rehold) begin
         job_data.cnt = n;
      end else begin
         job_data.cnt = n + 3'd1;
      end

      job_push = accept && (done || !prefix || eot);

      held_in  = held_ff;
      count_in = count_ff;
      alive_in = alive_ff;
      if (accept) begin
         if (prefix && !eot) begin
            for (int i = 0; i < HOLD_DEPTH; i++) begin
               if (3'(i) == n) begin
                  held_in[i] = nb;
               end
            end
            count_in = n + 3'd1;
            alive_in = alive_nx;
         end else if (rehold) begin
            held_in[0] = nb;
            count_in   = 3'd1;
            alive_in   = '1;
         end else begin
            count_in = 3'd0;
            alive_in = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         alive_ff <= '1;
      end else begin
         count_ff <= count_in;
         alive_ff <= alive_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (accept) begin
         acc_ff <= acc_in;
      end
   end

endmodule

// ===== rtl/xed_back.sv =====
// ----------------------------------------------------------------------------
// xed_back
// Takes jobs from the queue and emits their bytes one per transfer through
// the output register, marking the end of each run and of the text.
// ----------------------------------------------------------------------------
module xed_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  xed_pkg::job_type job_head,
   output logic             job_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output xed_pkg::rsp_type rsp_data
);
   import xed_pkg::*;

   job_type    job_ff, job_in;
   logic       busy_ff, busy_in;
   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   rsp_type    out_ff, out_in;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      logic out_adv;
      logic last;

      out_adv = !out_valid_ff || rsp_ready;
      last    = (idx_ff == (job_ff.cnt - 3'd1));

      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      idx_in       = idx_ff;
      busy_in      = busy_ff;
      job_in       = job_ff;

      if (busy_ff && out_adv) begin
         out_valid_in       = 1'b1;
         out_in.out_byte    = job_ff.bytes[idx_ff];
         out_in.run_last    = last;
         out_in.text_last   = last && job_ff.eot;
         idx_in             = idx_ff + 3'd1;
         if (last) begin
            busy_in = 1'b0;
         end
      end

      job_pop = job_valid && (!busy_ff || (out_adv && last));
      if (job_pop) begin
         job_in  = job_head;
         busy_in = 1'b1;
         idx_in  = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

endmodule

// ===== test/xed_decode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xed_decode_checker
// Watches both channels of the entity decoder. It predicts the decoded bytes
// of every accepted text byte and compares each response transfer, field by
// field, with the oldest expected byte.
// ----------------------------------------------------------------------------
module xed_decode_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  xed_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  xed_pkg::rsp_type rsp_data,
   output int               mismatches,
   output int               pending
);

   import xed_pkg::*;

   typedef enum logic [1:0] {CAND_DEAD, CAND_OPEN, CAND_DONE} cand_type;

   logic [7:0] held_text [0:4];
   int         held_cnt;
   rsp_type    decoded_q [$];
   rsp_type    want;
   int         rsp_index;

   function automatic string entity_name(input int k);
      case (k)
         0: return "&lt;";
         1: return "&gt;";
         2: return "&apos;";
         3: return "&quot;";
         default: return "&amp;";
      endcase
   endfunction

   function automatic logic [7:0] entity_char(input int k);
      case (k)
         0: return "<";
         1: return ">";
         2: return "'";
         3: return "\"";
         default: return "&";
      endcase
   endfunction

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   // numeric forms: &#ddd; with value 128..255, &#xhh; lowercase, first digit 8..f
   function automatic cand_type number_kind(input logic [7:0] cand [0:5], input int n,
                                            output logic [7:0] value);
      int v;
      int d;
      int lo;
      int hi;
      value = '0;
      if (n >= 2 && cand[1] != "#") return CAND_DEAD;
      if (n <= 2) return CAND_OPEN;
      if (cand[2] == "x") begin
         v = 0;
         for (int i = 3; i < n && i < 5; i++) begin
            d = hex_value(cand[i]);
            if (d < 0 || (i == 3 && d < 8)) return CAND_DEAD;
            v = v * 16 + d;
         end
         if (n <= 5) return CAND_OPEN;
         if (cand[5] != ";") return CAND_DEAD;
         value = v[7:0];
         return CAND_DONE;
      end
      lo = 0;
      hi = 0;
      for (int i = 2; i < 5; i++) begin
         if (i < n) begin
            if (cand[i] < "0" || cand[i] > "9") return CAND_DEAD;
            lo = lo * 10 + int'(cand[i]) - int'("0");
            hi = hi * 10 + int'(cand[i]) - int'("0");
         end else begin
            lo = lo * 10;
            hi = hi * 10 + 9;
         end
      end
      if (hi < 128 || lo > 255) return CAND_DEAD;
      if (n <= 5) return CAND_OPEN;
      if (cand[5] != ";") return CAND_DEAD;
      value = lo[7:0];
      return CAND_DONE;
   endfunction

   function automatic cand_type cand_kind(input logic [7:0] cand [0:5], input int n,
                                          output logic [7:0] value);
      string      nm;
      cand_type   kind;
      cand_type   num;
      logic [7:0] nv;
      bit         same;
      value = '0;
      kind  = CAND_DEAD;
      if (n == 0 || cand[0] != "&") return CAND_DEAD;
      for (int k = 0; k < 5; k++) begin
         nm = entity_name(k);
         if (n <= nm.len()) begin
            same = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (cand[i] != nm[i]) same = 1'b0;
            end
            if (same && n == nm.len()) begin
               value = entity_char(k);
               return CAND_DONE;
            end
            if (same) kind = CAND_OPEN;
         end
      end
      num = number_kind(cand, n, nv);
      if (num == CAND_DONE) begin
         value = nv;
         return CAND_DONE;
      end
      if (num == CAND_OPEN) kind = CAND_OPEN;
      return kind;
   endfunction

   task automatic decode_byte(input req_type item);
      logic [7:0] scan [0:5];
      logic [7:0] outs [$];
      logic [7:0] value;
      rsp_type    e;
      cand_type   kind;
      int         n;
      bit         waiting;
      n = held_cnt;
      for (int i = 0; i < n; i++) scan[i] = held_text[i];
      scan[n] = item.in_byte;
      n++;
      waiting = 1'b0;
      // drop leading bytes until the rest can still become an entity
      while (n > 0 && !waiting) begin
         kind = cand_kind(scan, n, value);
         if (kind == CAND_DONE) begin
            outs.push_back(value);
            n = 0;
         end else if (kind == CAND_OPEN) begin
            waiting = 1'b1;
         end else begin
            outs.push_back(scan[0]);
            for (int i = 1; i < n; i++) scan[i-1] = scan[i];
            n--;
         end
      end
      if (item.end_of_text) begin
         for (int i = 0; i < n; i++) outs.push_back(scan[i]);
         n = 0;
      end
      for (int i = 0; i < n; i++) held_text[i] = scan[i];
      held_cnt = n;
      foreach (outs[i]) begin
         e.out_byte  = outs[i];
         e.run_last  = (i == outs.size() - 1);
         e.text_last = item.end_of_text && e.run_last;
         decoded_q.push_back(e);
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      if (mismatches < 200) begin
         $display("checker: output %0d %s: got 0x%0h, expected 0x%0h",
                  rsp_index, what, got, exp_val);
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_cnt   = 0;
         rsp_index  = 0;
         mismatches = 0;
         decoded_q.delete();
      end else begin
         if (req_valid && req_ready) decode_byte(req_data);
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("transfer with nothing expected, out_byte",
                               rsp_data.out_byte, 0);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
               if (rsp_data.run_last !== want.run_last)
                  report_mismatch("run_last", rsp_data.run_last, want.run_last);
               if (rsp_data.text_last !== want.text_last)
                  report_mismatch("text_last", rsp_data.text_last, want.text_last);
            end
            rsp_index++;
         end
      end
      pending = decoded_q.size();
   end

endmodule

// ===== test/tb_xml_entity_decoder_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_xml_entity_decoder_core
// Drives text bytes into the entity decoder: a few directed strings, then
// random text built mostly from whole entities with random content, mixed
// with raw bytes and cut or corrupted entities. Both sides idle at random and
// the receiver holds off once for a long stretch. The checker does the rest.
// ----------------------------------------------------------------------------
module tb_xml_entity_decoder_core;

   import xed_pkg::*;

   localparam int ITEM_TARGET     = 470;
   localparam int WATCHDOG_LIMIT  = 3000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int DRAIN_CYCLES    = 20;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int         mismatches;
   int         pending;
   req_type    text_q [$];
   logic [7:0] tok_q [$];
   bit         hold_off_req;
   bit         hold_off_done;
   int         burst_at;

   xml_entity_decoder_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   xed_decode_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_byte(input logic [7:0] b, input bit eot);
      req_type item;
      item.in_byte     = b;
      item.end_of_text = eot;
      text_q.push_back(item);
   endtask

   task automatic add_text(input string s, input bit eot_last);
      for (int i = 0; i < s.len(); i++) add_byte(s[i], eot_last && (i == s.len() - 1));
   endtask

   // one token of random text: raw bytes, an entity, or a broken entity
   task automatic build_token();
      string s;
      int    r;
      int    k;
      int    cut;
      tok_q.delete();
      r = $urandom_range(0, 99);
      if (r < 25) begin
         repeat ($urandom_range(1, 3)) tok_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      k = (r < 86) ? r : $urandom_range(25, 85);
      if (k < 45) begin
         case ($urandom_range(0, 4))
            0: s = "&lt;";
            1: s = "&gt;";
            2: s = "&apos;";
            3: s = "&quot;";
            default: s = "&amp;";
         endcase
      end else if (k < 60) begin
         s = $sformatf("&#%0d;", $urandom_range(128, 255));
      end else if (k < 72) begin
         s = $sformatf("&#x%02x;", $urandom_range(128, 255));
      end else if (k < 80) begin
         if ($urandom_range(0, 2) != 0) s = $sformatf("&#%03d;", $urandom_range(0, 999));
         else s = $sformatf("&#%0d;", $urandom_range(0, 9999));
      end else begin
         case ($urandom_range(0, 2))
            0: s = $sformatf("&#x%02x;", $urandom_range(0, 255));
            1: s = $sformatf("&#x%02X;", $urandom_range(0, 255));
            default: s = $sformatf("&#x%0x;", $urandom_range(0, 4095));
         endcase
      end
      for (int i = 0; i < s.len(); i++) tok_q.push_back(s[i]);
      if (r >= 86) begin
         if ($urandom_range(0, 1) != 0) begin
            cut = $urandom_range(1, tok_q.size() - 1);
            while (tok_q.size() > cut) void'(tok_q.pop_back());
         end else begin
            tok_q[$urandom_range(1, tok_q.size() - 1)] = 8'($urandom_range(0, 255));
         end
      end
   endtask

   initial begin
      req_type item;
      int      gap;
      int      calm_left;
      int      burst_left;
      calm_left  = 0;
      burst_left = 0;
      add_byte(8'h00, 1'b0);
      add_text("&#128;", 1'b0);
      add_text("&#127;", 1'b0);
      add_text("&#xff;", 1'b0);
      add_text("&a", 1'b0);
      add_byte(8'hff, 1'b1);
      add_text("&qu", 1'b1);
      burst_at = text_q.size() + 120;
      while (text_q.size() < ITEM_TARGET) begin
         build_token();
         foreach (tok_q[i]) add_byte(tok_q[i], $urandom_range(0, 39) == 0);
      end
      item = text_q.pop_back();
      item.end_of_text = 1'b1;
      text_q.push_back(item);

      wait (!reset);
      @(posedge clock);
      for (int idx = 0; idx < text_q.size(); idx++) begin
         if (idx == burst_at) begin
            burst_left   = 80;
            hold_off_req = 1'b1;
         end
         gap = 0;
         if (burst_left > 0) begin
            burst_left--;
         end else if (calm_left > 0) begin
            calm_left--;
         end else begin
            gap = pick_gap();
            if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 60);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= text_q[idx];
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8))
            @(posedge clock);
      end
   end

   // no transfer on either channel for too long
   initial begin
      int idle;
      idle = 0;
      wait (!reset);
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
